// ===== hw/rtl/lzss_pkg.sv =====
// Shared types and constants for the LZSS stream decoder.
package lzss_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int MATCH_MAX = 18;
    localparam int MATCH_MIN = 3;
    localparam int LEN_W     = 4;
    localparam int FLAG_BITS = 8;

    // copy count holds length - 1, up to MATCH_MAX - 1
    localparam int CNT_W     = $clog2(MATCH_MAX);

    // source index = position - (WIN_DEPTH - MATCH_MAX) mod WIN_DEPTH
    localparam logic [WIN_AW-1:0] SRC_BIAS  = WIN_AW'(MATCH_MAX);
    localparam logic [LEN_W-1:0]  FLAG_LOAD = LEN_W'(FLAG_BITS);
    localparam logic [CNT_W-1:0]  CNT_BIAS  = CNT_W'(MATCH_MIN - 1);

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_DATA,
        PH_HIGH
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_CPY,
        CMD_CLR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        data;
        logic [WIN_AW-1:0] src;
        logic [CNT_W-1:0]  cnt;
        logic              last;
    } cmd_t;

endpackage

// ===== hw/rtl/lzss_if.sv =====
// Valid/ready stream interfaces for compressed input and decoded output.
interface lzss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

// ===== hw/rtl/lzss_front.sv =====
// Token parser: tracks flags and phase, turns input bytes into commands.
module lzss_front (
    input  logic           clk,
    input  logic           rst_n,
    lzss_in_if.sink        comp,
    output logic           cmd_valid,
    output lzss_pkg::cmd_t cmd,
    input  logic           cmd_full
);

    lzss_pkg::phase_t                    phase_reg, phase_next;
    logic [lzss_pkg::FLAG_BITS-1:0]      shift_reg, shift_next;
    logic [lzss_pkg::LEN_W-1:0]          left_reg, left_next;
    logic [7:0]                          held_reg, held_next;
    logic                                acc;

    assign comp.ready = !cmd_full;
    assign acc        = comp.valid && comp.ready;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        held_next  = held_reg;
        if (acc)
        begin
            unique case (phase_reg)
                lzss_pkg::PH_DATA:
                begin
                    if (shift_reg[0])
                    begin
                        shift_next = shift_reg >> 1;
                        left_next  = left_reg - 1'b1;
                        phase_next = (left_reg == 4'd1) ? lzss_pkg::PH_FLAG
                                                         : lzss_pkg::PH_DATA;
                    end
                    else
                    begin
                        held_next  = comp.in_byte;
                        phase_next = lzss_pkg::PH_HIGH;
                    end
                end
                lzss_pkg::PH_HIGH:
                begin
                    shift_next = shift_reg >> 1;
                    left_next  = left_reg - 1'b1;
                    phase_next = (left_reg == 4'd1) ? lzss_pkg::PH_FLAG
                                                     : lzss_pkg::PH_DATA;
                end
                default:
                begin
                    shift_next = comp.in_byte;
                    left_next  = lzss_pkg::FLAG_LOAD;
                    phase_next = lzss_pkg::PH_DATA;
                end
            endcase
            if (comp.in_last)
            begin
                phase_next = lzss_pkg::PH_FLAG;
                shift_next = '0;
                left_next  = '0;
                held_next  = '0;
            end
        end
    end

    always_comb
    begin
        cmd_valid = 1'b0;
        cmd.kind  = lzss_pkg::CMD_CLR;
        cmd.data  = comp.in_byte;
        cmd.src   = {comp.in_byte[7:4], held_reg} + lzss_pkg::SRC_BIAS;
        cmd.cnt   = {1'b0, comp.in_byte[3:0]} + lzss_pkg::CNT_BIAS;
        cmd.last  = comp.in_last;
        if (acc)
        begin
            unique case (phase_reg)
                lzss_pkg::PH_DATA:
                begin
                    if (shift_reg[0])
                    begin
                        cmd_valid = 1'b1;
                        cmd.kind  = lzss_pkg::CMD_LIT;
                    end
                    else
                    begin
                        cmd_valid = comp.in_last;
                    end
                end
                lzss_pkg::PH_HIGH:
                begin
                    cmd_valid = 1'b1;
                    cmd.kind  = lzss_pkg::CMD_CPY;
                end
                default:
                begin
                    cmd_valid = comp.in_last;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lzss_pkg::PH_FLAG;
            shift_reg <= '0;
            left_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== hw/rtl/lzss_cmd_fifo.sv =====
// Short command queue between the parser and the copy engine.
module lzss_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lzss_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output lzss_pkg::cmd_t head_cmd,
    input  logic           pop
);

    lzss_pkg::cmd_t                slot_reg [lzss_pkg::CQ_DEPTH];
    logic [lzss_pkg::CQ_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [lzss_pkg::CQ_AW:0]      count_reg;
    logic                          do_push, do_pop;

    assign full       = (count_reg == (lzss_pkg::CQ_AW+1)'(lzss_pkg::CQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/lzss_back.sv =====
// Copy engine: history window, per-byte read/emit pipeline and output register.
module lzss_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  lzss_pkg::cmd_t cmd,
    output logic           cmd_pop,
    lzss_out_if.source     plain
);

    logic [7:0]                    win_mem [lzss_pkg::WIN_DEPTH];
    logic [7:0]                    rd_data_reg;

    logic                          busy_reg;
    logic [lzss_pkg::WIN_AW-1:0]   src_reg;
    logic [lzss_pkg::CNT_W-1:0]    left_reg;
    logic                          cend_reg;

    logic [lzss_pkg::WIN_AW-1:0]   wp_reg;
    logic                          full_reg;

    logic                          e_valid_reg;
    logic                          e_lit_reg;
    logic [7:0]                    e_byte_reg;
    logic                          e_zero_reg;
    logic                          e_fwd_reg;
    logic                          e_end_reg;
    logic                          e_clr_reg;
    logic [7:0]                    wr_byte_reg;

    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic                          out_end_reg;

    logic                          out_free, e_adv, slot_free, issue, fwd, seen;
    logic                          lit_load, cpy_load, clr_load;
    logic [7:0]                    e_val;

    assign out_free  = !out_valid_reg || plain.ready;
    assign e_adv     = e_valid_reg && out_free;
    assign slot_free = !e_valid_reg || (e_adv && !e_clr_reg);
    assign issue     = busy_reg && slot_free;
    assign fwd       = e_valid_reg && (src_reg == wp_reg);
    assign seen      = full_reg || (src_reg < wp_reg);

    always_comb
    begin
        priority if (e_lit_reg)
            e_val = e_byte_reg;
        else if (e_zero_reg)
            e_val = '0;
        else if (e_fwd_reg)
            e_val = wr_byte_reg;
        else
            e_val = rd_data_reg;
    end

    always_comb
    begin
        cmd_pop = 1'b0;
        if (!busy_reg && cmd_valid)
        begin
            unique case (cmd.kind)
                lzss_pkg::CMD_LIT: cmd_pop = slot_free;
                lzss_pkg::CMD_CPY: cmd_pop = 1'b1;
                lzss_pkg::CMD_CLR: cmd_pop = !e_valid_reg;
                default:           cmd_pop = 1'b1;
            endcase
        end
    end

    assign lit_load = cmd_pop && (cmd.kind == lzss_pkg::CMD_LIT);
    assign cpy_load = cmd_pop && (cmd.kind == lzss_pkg::CMD_CPY);
    assign clr_load = cmd_pop && (cmd.kind == lzss_pkg::CMD_CLR);

    assign plain.valid    = out_valid_reg;
    assign plain.out_byte = out_byte_reg;
    assign plain.run_end  = out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            src_reg       <= '0;
            left_reg      <= '0;
            cend_reg      <= 1'b0;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cpy_load)
            begin
                busy_reg <= 1'b1;
                src_reg  <= cmd.src;
                left_reg <= cmd.cnt;
                cend_reg <= cmd.last;
            end
            else if (issue)
            begin
                src_reg  <= src_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
                if (left_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (issue || lit_load)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
            end

            if (clr_load || (e_adv && e_clr_reg))
            begin
                wp_reg   <= '0;
                full_reg <= 1'b0;
            end
            else if (e_adv)
            begin
                wp_reg   <= wp_reg + 1'b1;
                full_reg <= full_reg || (&wp_reg);
            end

            if (e_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (plain.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            e_lit_reg  <= 1'b0;
            e_zero_reg <= !seen && !fwd;
            e_fwd_reg  <= fwd;
            e_end_reg  <= (left_reg == '0);
            e_clr_reg  <= (left_reg == '0) && cend_reg;
        end
        else if (lit_load)
        begin
            e_lit_reg  <= 1'b1;
            e_byte_reg <= cmd.data;
            e_zero_reg <= 1'b0;
            e_fwd_reg  <= 1'b0;
            e_end_reg  <= 1'b1;
            e_clr_reg  <= cmd.last;
        end
        if (e_adv)
        begin
            wr_byte_reg  <= e_val;
            out_byte_reg <= e_val;
            out_end_reg  <= e_end_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_adv)
        begin
            win_mem[wp_reg] <= e_val;
        end
        if (issue)
        begin
            rd_data_reg <= win_mem[src_reg];
        end
    end

    ap_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (e_adv && !e_clr_reg) |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write pointer did not advance after a byte transfer");

    ap_wp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (e_adv && e_clr_reg) |=> (wp_reg == '0 && !full_reg))
        else $error("window fill state not cleared after end of stream");

    ap_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        e_adv |=> (plain.valid && plain.out_byte == $past(e_val)))
        else $error("output register lost an emitted byte");

endmodule

// ===== hw/rtl/lzss_stream_decoder_core.sv =====
// LZSS stream decoder top level: parser, command queue and copy engine.
// A literal yields one output byte; a reference of N bytes (3..18) is expanded by
// the copy engine with one window read per output byte, and holds off new commands until done.
// Path from input to output: command queue, emit stage, output register.
// Reset (async, active low) clears all control state; the window is not swept:
// entries past the write pointer read as zero until written, also after the last byte.
module lzss_stream_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    lzss_in_if.sink     comp,
    lzss_out_if.source  plain
);

    logic           push_valid;
    lzss_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           head_valid;
    lzss_pkg::cmd_t head_cmd;
    logic           pop;

    lzss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .comp      (comp),
        .cmd_valid (push_valid),
        .cmd       (push_cmd),
        .cmd_full  (q_full)
    );

    lzss_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    lzss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .plain     (plain)
    );

endmodule
